### hdl/sset_pkg.sv
// Shared types, constants and helpers for the sensor scale and extreme tracker.
package sset_pkg;

  localparam int RawW    = 16;
  localparam int SecondW = 6;
  localparam int HumW    = 7;
  localparam int TempW   = 9;
  localparam int CfgIdxW = 2;
  localparam int ProdW   = 24;

  localparam logic [ProdW-1:0] HumGain  = 24'd125;
  localparam logic [ProdW-1:0] TempGain = 24'd175;
  localparam logic [7:0]       HumOffset  = 8'd6;
  localparam logic [TempW-1:0] TempOffset = 9'd46;

  localparam logic [TempW-1:0]   ColdReset   = 9'sd20;
  localparam logic [TempW-1:0]   WarmReset   = 9'sd40;
  localparam logic [TempW-1:0]   HotReset    = 9'sd60;
  localparam logic [SecondW-1:0] SecondReset = 6'd60;
  localparam logic [HumW-1:0]    HumHighReset  = 7'd0;
  localparam logic [HumW-1:0]    HumLowReset   = 7'd101;
  localparam logic [TempW-1:0]   TempHighReset = 9'h1CE;  // -50
  localparam logic [TempW-1:0]   TempLowReset  = 9'd150;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COLD = 2'd0,
    CFG_WARM = 2'd1,
    CFG_HOT  = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    BAND_SKY    = 2'd0,
    BAND_GREEN  = 2'd1,
    BAND_YELLOW = 2'd2,
    BAND_RED    = 2'd3
  } band_t;

  typedef struct packed {
    logic signed [TempW-1:0] cold;
    logic signed [TempW-1:0] warm;
    logic signed [TempW-1:0] hot;
  } limits_t;

  typedef struct packed {
    logic [HumW-1:0]         humidity;
    logic signed [TempW-1:0] temperature;
    band_t                   band;
  } scaled_t;

  typedef struct packed {
    logic emit;
    logic hum_high;
    logic hum_low;
    logic temp_high;
    logic temp_low;
  } track_t;

  // Floor of x / 65535 for x below 256 * 65535: fold the high half back in.
  function automatic logic [7:0] div65535(input logic [ProdW-1:0] x);
    logic [ProdW:0] s;
    s = {1'b0, x} + {17'd0, x[ProdW-1:16]} + 25'd1;
    return s[23:16];
  endfunction

endpackage

### hdl/sset_in_if.sv
// Input channel carrying one raw sensor word per handshake.
interface sset_in_if;
  logic                           valid;
  logic                           ready;
  logic [sset_pkg::RawW-1:0]      raw_humidity;
  logic [sset_pkg::RawW-1:0]      raw_temperature;
  logic [sset_pkg::SecondW-1:0]   second;

  modport source (output valid, output raw_humidity, output raw_temperature,
                  output second, input ready);
  modport sink   (input valid, input raw_humidity, input raw_temperature,
                  input second, output ready);
endinterface

### hdl/sset_out_if.sv
// Output channel carrying one scaled result word per handshake.
interface sset_out_if;
  logic                               valid;
  logic                               ready;
  logic [sset_pkg::HumW-1:0]          humidity_percent;
  logic signed [sset_pkg::TempW-1:0]  temperature_celsius;
  logic [1:0]                         colour_band;
  logic                               humidity_new_high;
  logic                               humidity_new_low;
  logic                               temperature_new_high;
  logic                               temperature_new_low;

  modport source (output valid, output humidity_percent, output temperature_celsius,
                  output colour_band, output humidity_new_high, output humidity_new_low,
                  output temperature_new_high, output temperature_new_low, input ready);
  modport sink   (input valid, input humidity_percent, input temperature_celsius,
                  input colour_band, input humidity_new_high, input humidity_new_low,
                  input temperature_new_high, input temperature_new_low, output ready);
endinterface

### hdl/sensor_scale_and_extreme_tracker.sv
// Top level: input register, scaling and extreme tracking, result register.
// Words pass the input register, then the result register, at one word per
// cycle unless the result side stalls; the input register feeds the scaler and
// tracker, whose state updates in the same edge that loads the result register.
// Words whose second repeats the previous one are dropped and give no result.
// Reset (synchronous, active high) restores limits 20/40/60, last second 60 and
// the extreme registers, and empties both pipeline registers.
module sensor_scale_and_extreme_tracker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [sset_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [sset_pkg::TempW-1:0]   cfg_data,
  sset_in_if.sink                      sample,
  sset_out_if.source                   result
);

  // Color band limits.
  sset_pkg::limits_t limits;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.cold <= sset_pkg::ColdReset;
      limits.warm <= sset_pkg::WarmReset;
      limits.hot  <= sset_pkg::HotReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sset_pkg::CFG_COLD: limits.cold <= cfg_data;
        sset_pkg::CFG_WARM: limits.warm <= cfg_data;
        sset_pkg::CFG_HOT:  limits.hot  <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Input register.
  logic                         in_valid;
  logic [sset_pkg::RawW-1:0]    in_raw_humidity;
  logic [sset_pkg::RawW-1:0]    in_raw_temperature;
  logic [sset_pkg::SecondW-1:0] in_second;
  logic                         advance;

  // Advance whenever the result register is free or being emptied.
  assign advance      = !result.valid || result.ready;
  assign sample.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      in_raw_humidity    <= sample.raw_humidity;
      in_raw_temperature <= sample.raw_temperature;
      in_second          <= sample.second;
    end
  end

  // Scale and track.
  sset_pkg::scaled_t scaled;
  sset_pkg::track_t  track;
  logic              step;

  assign step = in_valid && advance;

  sset_scale u_scale (
    .raw_humidity    (in_raw_humidity),
    .raw_temperature (in_raw_temperature),
    .limits          (limits),
    .scaled          (scaled)
  );

  sset_track u_track (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .second (in_second),
    .scaled (scaled),
    .track  (track)
  );

  // Result register: load a word only when the second changed.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= step && track.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && track.emit) begin
      result.humidity_percent     <= scaled.humidity;
      result.temperature_celsius  <= scaled.temperature;
      result.colour_band          <= scaled.band;
      result.humidity_new_high    <= track.hum_high;
      result.humidity_new_low     <= track.hum_low;
      result.temperature_new_high <= track.temp_high;
      result.temperature_new_low  <= track.temp_low;
    end
  end

endmodule

### hdl/sset_scale.sv
// Scale raw readings to percent and Celsius and pick the colour band.
module sset_scale (
  input  logic [sset_pkg::RawW-1:0] raw_humidity,
  input  logic [sset_pkg::RawW-1:0] raw_temperature,
  input  sset_pkg::limits_t         limits,
  output sset_pkg::scaled_t         scaled
);

  logic [sset_pkg::ProdW-1:0] hum_prod;
  logic [sset_pkg::ProdW-1:0] temp_prod;
  logic [7:0]                 hum_q;
  logic [7:0]                 temp_q;
  logic signed [sset_pkg::TempW-1:0] temp;

  assign hum_prod  = {8'd0, raw_humidity} * sset_pkg::HumGain;
  assign temp_prod = {8'd0, raw_temperature} * sset_pkg::TempGain;
  assign hum_q     = sset_pkg::div65535(hum_prod);
  assign temp_q    = sset_pkg::div65535(temp_prod);
  assign temp      = $signed({1'b0, temp_q} - sset_pkg::TempOffset);

  always_comb begin
    scaled.temperature = temp;
    // Clamp humidity at zero instead of wrapping.
    if (hum_q < sset_pkg::HumOffset) begin
      scaled.humidity = '0;
    end else begin
      scaled.humidity = sset_pkg::HumW'(hum_q - sset_pkg::HumOffset);
    end
    priority if (temp < limits.cold) begin
      scaled.band = sset_pkg::BAND_SKY;
    end else if (temp < limits.warm) begin
      scaled.band = sset_pkg::BAND_GREEN;
    end else if (temp < limits.hot) begin
      scaled.band = sset_pkg::BAND_YELLOW;
    end else begin
      scaled.band = sset_pkg::BAND_RED;
    end
  end

endmodule

### hdl/sset_track.sv
// Running extremes and last-second filter, with new-extreme flags.
module sset_track (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [sset_pkg::SecondW-1:0] second,
  input  sset_pkg::scaled_t            scaled,
  output sset_pkg::track_t             track
);

  logic [sset_pkg::SecondW-1:0]      last_second;
  logic [sset_pkg::HumW-1:0]         highest_humidity;
  logic [sset_pkg::HumW-1:0]         lowest_humidity;
  logic signed [sset_pkg::TempW-1:0] highest_temperature;
  logic signed [sset_pkg::TempW-1:0] lowest_temperature;

  always_comb begin
    track.emit      = second != last_second;
    track.hum_high  = scaled.humidity > highest_humidity;
    track.hum_low   = scaled.humidity < lowest_humidity;
    track.temp_high = scaled.temperature > highest_temperature;
    track.temp_low  = scaled.temperature < lowest_temperature;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_second         <= sset_pkg::SecondReset;
      highest_humidity    <= sset_pkg::HumHighReset;
      lowest_humidity     <= sset_pkg::HumLowReset;
      highest_temperature <= sset_pkg::TempHighReset;
      lowest_temperature  <= sset_pkg::TempLowReset;
    end else if (step && track.emit) begin
      last_second <= second;
      if (track.hum_high)  highest_humidity    <= scaled.humidity;
      if (track.hum_low)   lowest_humidity     <= scaled.humidity;
      if (track.temp_high) highest_temperature <= scaled.temperature;
      if (track.temp_low)  lowest_temperature  <= scaled.temperature;
    end
  end

endmodule

### tb/sv/sensor_scale_and_extreme_tracker_tb.sv
// Self-checking testbench for the sensor scale and extreme tracker.
module sensor_scale_and_extreme_tracker_tb;
  import sset_pkg::*;

  // Index 3 decodes to no register; a write there must leave every limit alone.
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;
  // Two pipeline registers; settle beyond that depth before touching limits.
  localparam int PipeDepth  = 2;
  localparam int SettleWait = PipeDepth + 3;
  localparam int MaxIdle    = 17;
  localparam int HoldOff    = 300;
  localparam int RunLimit   = 300000;  // cycles

  typedef struct {
    logic [HumW-1:0]         humidity;
    logic signed [TempW-1:0] temperature;
    band_t                   band;
    logic                    hum_high;
    logic                    hum_low;
    logic                    temp_high;
    logic                    temp_low;
  } reading_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [TempW-1:0]   cfg_data;

  sset_in_if  sample_if ();
  sset_out_if result_if ();

  sensor_scale_and_extreme_tracker u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_if),
    .result    (result_if)
  );

  // Predictor state: limits, last second and the running extremes.
  logic signed [TempW-1:0] lim_cold = 20;
  logic signed [TempW-1:0] lim_warm = 40;
  logic signed [TempW-1:0] lim_hot  = 60;
  logic [SecondW-1:0]      seen_second = 60;
  int hum_peak   = 0;
  int hum_floor  = 101;
  int temp_peak  = -50;
  int temp_floor = 150;

  reading_t pending_readings[$];

  int mismatches      = 0;
  int words_sent      = 0;
  int results_checked = 0;
  int settings_used   = 1;
  int clock_second    = 0;

  // Idle controls for the sender and the receiver.
  bit tx_idle_on     = 0;
  bit rx_idle_on     = 0;
  int rx_hold_cycles = 0;
  int longest_hold   = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(RunLimit * 20);
    $display("Timeout after %0d cycles with %0d results outstanding", RunLimit,
             pending_readings.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Scale one sample, sort it into a band and update the extremes.
  // Return 0 when the second repeats: no result and no state change.
  function automatic bit scale_and_track(input logic [RawW-1:0] raw_h,
                                         input logic [RawW-1:0] raw_t,
                                         input logic [SecondW-1:0] sec,
                                         output reading_t r);
    int hum;
    int temp;
    if (sec == seen_second) begin
      return 1'b0;
    end
    seen_second = sec;
    hum = int'(raw_h) * 125 / 65535 - 6;
    if (hum < 0) begin
      hum = 0;  // the sensor reads below the offset near dry air
    end
    temp = int'(raw_t) * 175 / 65535 - 46;
    // Test the bands in order; red takes whatever the three limits leave.
    if (temp < int'(lim_cold)) begin
      r.band = BAND_SKY;
    end else if (temp < int'(lim_warm)) begin
      r.band = BAND_GREEN;
    end else if (temp < int'(lim_hot)) begin
      r.band = BAND_YELLOW;
    end else begin
      r.band = BAND_RED;
    end
    r.hum_high  = hum > hum_peak;
    r.hum_low   = hum < hum_floor;
    r.temp_high = temp > temp_peak;
    r.temp_low  = temp < temp_floor;
    if (r.hum_high) hum_peak = hum;
    if (r.hum_low) hum_floor = hum;
    if (r.temp_high) temp_peak = temp;
    if (r.temp_low) temp_floor = temp;
    r.humidity    = HumW'(hum);
    r.temperature = TempW'(temp);
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Sample both handshakes at the rising edge. Check the result word first,
  // then predict from the sample word; a word accepted now cannot answer now.
  always @(posedge clk) begin : watch_channels
    reading_t want;
    reading_t fresh;
    if (!rst) begin
      if (result_if.valid && result_if.ready) begin
        if (pending_readings.size() == 0) begin
          $error("result word with no sample pending");
          mismatches++;
        end else begin
          want = pending_readings.pop_front();
          if ($isunknown({result_if.humidity_percent, result_if.temperature_celsius,
                          result_if.colour_band, result_if.humidity_new_high,
                          result_if.humidity_new_low, result_if.temperature_new_high,
                          result_if.temperature_new_low})) begin
            $error("result word carries unknown bits");
            mismatches++;
          end
          check_field("humidity_percent", int'(want.humidity),
                      int'(result_if.humidity_percent));
          check_field("temperature_celsius", int'(want.temperature),
                      int'(result_if.temperature_celsius));
          check_field("colour_band", int'(want.band), int'(result_if.colour_band));
          check_field("humidity_new_high", int'(want.hum_high),
                      int'(result_if.humidity_new_high));
          check_field("humidity_new_low", int'(want.hum_low),
                      int'(result_if.humidity_new_low));
          check_field("temperature_new_high", int'(want.temp_high),
                      int'(result_if.temperature_new_high));
          check_field("temperature_new_low", int'(want.temp_low),
                      int'(result_if.temperature_new_low));
          results_checked++;
        end
      end
      if (sample_if.valid && sample_if.ready) begin
        words_sent++;
        if (scale_and_track(sample_if.raw_humidity, sample_if.raw_temperature,
                            sample_if.second, fresh)) begin
          pending_readings.push_back(fresh);
        end
      end
    end
  end

  // Receiver: drop ready for a drawn number of cycles, plus any hold-off the
  // current test has asked for, then hold it high until a word is taken.
  initial begin : take_results
    int idle;
    result_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      idle = rx_idle_on ? $urandom_range(0, MaxIdle) : 0;
      if (rx_hold_cycles > 0) begin
        idle += rx_hold_cycles;
        if (rx_hold_cycles > longest_hold) longest_hold = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (idle > 0) begin
        result_if.ready <= 1'b0;
        for (int n = 0; n < idle; n++) @(negedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid);
      @(negedge clk);
    end
  end

  // Offer one sample word; call at a falling edge, return at a falling edge.
  // Leave valid high so a back-to-back word needs no extra toggle.
  task automatic send_sample(input logic [RawW-1:0] raw_h, input logic [RawW-1:0] raw_t,
                             input logic [SecondW-1:0] sec);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MaxIdle) : 0;
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_if.valid           <= 1'b1;
    sample_if.raw_humidity    <= raw_h;
    sample_if.raw_temperature <= raw_t;
    sample_if.second          <= sec;
    do @(posedge clk); while (!sample_if.ready);
    @(negedge clk);
  endtask

  // Drop valid, wait for every expected result, then let the pipe settle so a
  // dropped repeat-second word is not still in flight.
  task automatic wait_for_idle();
    sample_if.valid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (SettleWait) @(negedge clk);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [TempW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
  endtask

  // Load all three limits back to back, then poke the spare index with junk.
  task automatic program_limits(input int cold, input int warm, input int hot);
    wait_for_idle();
    write_register(CFG_COLD, TempW'(cold));
    write_register(CFG_WARM, TempW'(warm));
    write_register(CFG_HOT, TempW'(hot));
    write_register(CfgSpare, TempW'($urandom));
    cfg_we <= 1'b0;
    lim_cold = TempW'(cold);
    lim_warm = TempW'(warm);
    lim_hot  = TempW'(hot);
    settings_used++;
    @(negedge clk);
  endtask

  // Smallest raw count that scales to the given temperature.
  function automatic logic [RawW-1:0] raw_for_temp(input int deg);
    if (deg < -46) deg = -46;
    if (deg > 129) deg = 129;
    return RawW'(((deg + 46) * 65535 + 174) / 175);
  endfunction

  function automatic logic [RawW-1:0] pick_raw_humidity();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return RawW'(3145 + $urandom_range(0, 1));  // either side of the clamp
      default: return RawW'($urandom);
    endcase
  endfunction

  // Bias toward the current band edges so every compare flips both ways.
  function automatic logic [RawW-1:0] pick_raw_temperature();
    int deg;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: begin
        case ($urandom_range(0, 2))
          0: deg = int'(lim_cold);
          1: deg = int'(lim_warm);
          default: deg = int'(lim_hot);
        endcase
        return raw_for_temp(deg - int'($urandom_range(0, 1)));
      end
      default: return RawW'($urandom);
    endcase
  endfunction

  // Mostly a ticking clock, with repeats and the odd stray second up to 63.
  function automatic logic [SecondW-1:0] pick_second();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 14) begin
      clock_second = (clock_second + 1) % 60;
      return SecondW'(clock_second);
    end else if (roll < 17) begin
      return SecondW'(clock_second);
    end
    return SecondW'($urandom_range(0, 63));
  endfunction

  task automatic send_random_burst(input int count);
    logic [RawW-1:0] raw_h;
    logic [RawW-1:0] raw_t;
    logic [SecondW-1:0] sec;
    repeat (count) begin
      raw_h = pick_raw_humidity();
      raw_t = pick_raw_temperature();
      sec   = pick_second();
      send_sample(raw_h, raw_t, sec);
    end
  endtask

  // Fixed words right after reset with default limits: the reset second,
  // the clamp, every band on both sides of its edge, and the top seconds.
  task automatic test_directed_words();
    tx_idle_on = 0;
    rx_idle_on = 0;
    send_sample(16'h1234, 16'h5678, 6'd60);      // matches the reset second
    send_sample(16'h0000, 16'h0000, 6'd0);       // both scales at the bottom
    send_sample(16'hFFFF, 16'hFFFF, 6'd0);       // repeat: dropped
    send_sample(16'hFFFF, 16'hFFFF, 6'd1);       // both scales at the top
    send_sample(16'd3145, raw_for_temp(19), 6'd2);
    send_sample(16'd3146, raw_for_temp(20), 6'd3);
    send_sample(16'hAAAA, raw_for_temp(39), 6'd4);
    send_sample(16'h5555, raw_for_temp(40), 6'd5);
    send_sample(16'h8000, raw_for_temp(59), 6'd6);
    send_sample(16'h7FFF, raw_for_temp(60), 6'd7);
    send_sample(16'h0001, 16'h0001, 6'd61);
    send_sample(16'hFFFE, 16'hFFFE, 6'd62);
    send_sample(16'h0001, 16'h8000, 6'd63);
    send_sample(16'h0000, 16'h0000, 6'd63);      // repeat at the top second
    send_sample(16'hFFFF, 16'h0000, 6'd59);
    send_sample(16'h0000, 16'hFFFF, 6'd0);
    send_sample(16'h5555, 16'hAAAA, 6'd1);
    send_sample(16'hAAAA, 16'h5555, 6'd2);
    clock_second = 2;
  endtask

  // Walk the limits through their extremes, a disordered set and full-width
  // patterns, with random traffic under each.
  task automatic test_limit_settings();
    tx_idle_on = 1;
    rx_idle_on = 1;
    program_limits(-46, -46, -46);
    send_random_burst(50);
    program_limits(129, 129, 129);
    send_random_burst(50);
    program_limits(129, 40, -46);     // disordered: bands tested in order
    send_random_burst(50);
    program_limits(-46, 41, 128);
    send_random_burst(50);
    program_limits(-256, 0, 255);     // every limit bit both ways
    send_random_burst(50);
    program_limits(20, 40, 60);
    send_random_burst(50);
  endtask

  // Long random traffic in four blocks, each with fresh limits and its own
  // mix of sender and receiver idling.
  task automatic test_random_traffic();
    for (int blk = 0; blk < 4; blk++) begin
      program_limits(int'($urandom_range(0, 175)) - 46, int'($urandom_range(0, 175)) - 46,
                     int'($urandom_range(0, 175)) - 46);
      tx_idle_on = (blk == 0) || (blk == 1);
      rx_idle_on = (blk == 0) || (blk == 2);
      send_random_burst(130);
      if (blk == 3) begin
        tx_idle_on = 1;
        rx_idle_on = 1;
      end
      send_random_burst(130);
    end
  endtask

  // Hold the receiver off while the sender streams new seconds back to back,
  // so the pipe fills and the block must stall its input.
  task automatic test_output_holdoff();
    wait_for_idle();
    tx_idle_on = 0;
    rx_idle_on = 0;
    rx_hold_cycles = HoldOff;
    repeat (40) begin
      clock_second = (clock_second + 1) % 60;
      send_sample(RawW'($urandom), RawW'($urandom), SecondW'(clock_second));
    end
    rx_idle_on = 1;
    tx_idle_on = 1;
    send_random_burst(40);
  endtask

  initial begin
    rst                       = 1'b1;
    cfg_we                    = 1'b0;
    cfg_index                 = CFG_COLD;
    cfg_data                  = '0;
    sample_if.valid           = 1'b0;
    sample_if.raw_humidity    = '0;
    sample_if.raw_temperature = '0;
    sample_if.second          = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_words();
    test_limit_settings();
    test_random_traffic();
    test_output_holdoff();

    wait_for_idle();
    if (pending_readings.size() != 0) begin
      $error("%0d expected results never arrived", pending_readings.size());
      mismatches++;
    end
    $display("Sent %0d sample words and checked %0d result words over %0d limit settings",
             words_sent, results_checked, settings_used);
    $display("Covered repeated and stray seconds, humidity clamp, band edges, %0d-cycle hold-off",
             longest_hold);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sensor_scale_and_extreme_tracker.f
hdl/sset_pkg.sv
hdl/sset_in_if.sv
hdl/sset_out_if.sv
hdl/sset_scale.sv
hdl/sset_track.sv
hdl/sensor_scale_and_extreme_tracker.sv
tb/sv/sensor_scale_and_extreme_tracker_tb.sv
